// ----- rtl/flc_pkg.sv -----
package flc_pkg;

   localparam int MAX_TAPS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int DATA_BITS  = 16;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 7;
   localparam int OUT_BITS   = 38;

   localparam logic [COUNT_BITS-1:0] TAP_COUNT_RESET = COUNT_BITS'(1);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic                        op;
      logic [INDEX_BITS-1:0]       tap_index;
      logic signed [DATA_BITS-1:0] data_value;
      logic                        last_sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] conv_value;
      logic                       last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Control travelling with an operand pair into the multiply-accumulate unit.
   typedef struct packed {
      logic vld;
      logic first;
      logic take;
   } mac_ctrl_type;

endpackage

// ----- rtl/flc_ram.sv -----
module flc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/flc_mac.sv -----
module flc_mac #(
   parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  flc_pkg::mac_ctrl_type               ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       coef,
   input  logic signed [SAMPLE_BITS-1:0]       opnd,
   output logic signed [flc_pkg::OUT_BITS-1:0] acc,
   output logic                                busy
);

   localparam int PROD_BITS = 2 * SAMPLE_BITS;

   logic signed [PROD_BITS-1:0]         prod_in;
   logic signed [PROD_BITS-1:0]         prod_ff;
   logic                                b_vld_ff;
   logic                                b_first_ff;
   logic signed [flc_pkg::OUT_BITS-1:0] acc_in;
   logic signed [flc_pkg::OUT_BITS-1:0] acc_ff;

   // Both arms are signed so the operands are sign-extended before the multiply.
   assign prod_in = ctrl.take ? coef * opnd : PROD_BITS'(0);

   // The product is sign-extended or wrapped to the accumulator width.
   assign acc_in = (b_first_ff ? '0 : acc_ff) + flc_pkg::OUT_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= ctrl.vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      b_first_ff <= ctrl.first;
      if (b_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = b_vld_ff;

endmodule

// ----- rtl/full_linear_convolution.sv -----
// A coefficient load does not leave the idle state, so the block is ready again at once.
// A sample is accepted in the idle state and leaves its word in the output register
// after one shared multiply-accumulate walks all MAX_TAPS positions, then drains.
// The last sample adds tail words, one fewer than tap_count clamped to 1..MAX_TAPS.
// Synchronous active-high reset clears the kernel valid bits, the history and the state,
// and sets tap_count to one.
module full_linear_convolution #(
   parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  flc_pkg::req_type                   req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output flc_pkg::rsp_type                   rsp_word,
   input  logic                               csr_write,
   input  logic [flc_pkg::COUNT_BITS-1:0]     csr_wdata
);

   localparam int AW     = $clog2(MAX_TAPS);
   localparam int CW     = $clog2(MAX_TAPS + 1);
   localparam int HIST_D = MAX_TAPS - 1;

   localparam logic [AW-1:0] K_LAST = AW'(MAX_TAPS - 1);

   flc_pkg::state_type state_ff, state_in;

   logic [flc_pkg::COUNT_BITS-1:0] tap_count_ff;
   logic [CW-1:0]                  active_taps;
   logic [CW-1:0]                  taps_ff;
   logic [AW-1:0]                  k_ff;
   logic [AW-1:0]                  out_cnt_ff;
   logic                           last_ff;
   logic signed [SAMPLE_BITS-1:0]  x_ff;
   logic signed [SAMPLE_BITS-1:0]  hist_ff [HIST_D];
   logic [MAX_TAPS-1:0]            coef_vld_ff;

   logic                           accept;
   logic                           load_go;
   logic                           issue;
   logic                           out_go;
   logic                           final_out;
   logic signed [SAMPLE_BITS-1:0]  sample;

   flc_pkg::mac_ctrl_type          a_ctrl_ff, a_ctrl_in, mac_ctrl;
   logic                           coef_ok_ff;
   logic signed [SAMPLE_BITS-1:0]  opnd_ff;
   logic [SAMPLE_BITS-1:0]         coef_rd;
   logic signed [flc_pkg::OUT_BITS-1:0] acc;
   logic                           mac_busy;

   logic                           rsp_valid_ff;
   flc_pkg::rsp_type               rsp_word_ff;

   // Low SAMPLE_BITS of the field, zero-extended first, then taken as signed.
   assign sample = $signed(SAMPLE_BITS'($unsigned(req_word.data_value)));

   always_comb begin
      if (tap_count_ff == '0) begin
         active_taps = CW'(1);
      end else if (tap_count_ff > flc_pkg::COUNT_BITS'(MAX_TAPS)) begin
         active_taps = CW'(MAX_TAPS);
      end else begin
         active_taps = CW'(tap_count_ff);
      end
   end

   assign final_out = last_ff && (CW'(out_cnt_ff) == taps_ff - CW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flc_pkg::ST_IDLE: begin
            if (req_valid && req_word.op == flc_pkg::OP_SAMPLE) begin
               state_in = flc_pkg::ST_MAC;
            end
         end
         flc_pkg::ST_MAC: begin
            if (k_ff == K_LAST) begin
               state_in = flc_pkg::ST_DRAIN;
            end
         end
         flc_pkg::ST_DRAIN: begin
            if (!a_ctrl_ff.vld) begin
               state_in = flc_pkg::ST_OUT;
            end
         end
         flc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = (last_ff && !final_out) ? flc_pkg::ST_MAC : flc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      issue     = 1'b0;
      out_go    = 1'b0;
      unique case (state_ff)
         flc_pkg::ST_IDLE:  req_stall = 1'b0;
         flc_pkg::ST_MAC:   issue = 1'b1;
         flc_pkg::ST_DRAIN: ;
         flc_pkg::ST_OUT:   out_go = !rsp_valid_ff || !rsp_stall;
      endcase
   end

   assign accept  = req_valid && !req_stall;
   assign load_go = accept && req_word.op == flc_pkg::OP_LOAD &&
                    ({1'b0, req_word.tap_index} < flc_pkg::COUNT_BITS'(MAX_TAPS));

   always_comb begin
      a_ctrl_in.vld   = issue;
      a_ctrl_in.first = issue && k_ff == '0;
      a_ctrl_in.take  = issue && (CW'(k_ff) < taps_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flc_pkg::ST_IDLE;
         tap_count_ff <= flc_pkg::TAP_COUNT_RESET;
         coef_vld_ff  <= '0;
         a_ctrl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         a_ctrl_ff <= a_ctrl_in;
         if (csr_write) begin
            tap_count_ff <= csr_wdata;
         end
         if (load_go) begin
            coef_vld_ff[AW'(req_word.tap_index)] <= 1'b1;
         end
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sample history: rotates once per issued tap after the first so the next older sample
   // always sits at the head, and has gone full circle when the walk ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_D; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (issue && k_ff != '0) begin
         for (int i = 0; i < HIST_D - 1; i++) begin
            hist_ff[i] <= hist_ff[i+1];
         end
         hist_ff[HIST_D-1] <= hist_ff[0];
      end else if (out_go) begin
         if (final_out) begin
            for (int i = 0; i < HIST_D; i++) begin
               hist_ff[i] <= '0;
            end
         end else begin
            for (int i = 1; i < HIST_D; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
            hist_ff[0] <= x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.op == flc_pkg::OP_SAMPLE) begin
         x_ff       <= sample;
         last_ff    <= req_word.last_sample;
         taps_ff    <= active_taps;
         out_cnt_ff <= '0;
         k_ff       <= '0;
      end else if (issue) begin
         k_ff <= k_ff + AW'(1);
      end else if (out_go) begin
         x_ff       <= '0;
         out_cnt_ff <= out_cnt_ff + AW'(1);
         k_ff       <= '0;
      end
      opnd_ff    <= (k_ff == '0) ? x_ff : hist_ff[0];
      coef_ok_ff <= coef_vld_ff[k_ff];
      if (out_go) begin
         rsp_word_ff.conv_value  <= acc;
         rsp_word_ff.last_result <= final_out;
      end
   end

   flc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (AW'(req_word.tap_index)),
      .wr_data (sample),
      .rd_addr (k_ff),
      .rd_data (coef_rd)
   );

   always_comb begin
      mac_ctrl      = a_ctrl_ff;
      mac_ctrl.take = a_ctrl_ff.take && coef_ok_ff;
   end

   flc_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  ($signed(coef_rd)),
      .opnd  (opnd_ff),
      .acc   (acc),
      .busy  (mac_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_pipe_empty_at_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == flc_pkg::ST_OUT |-> !a_ctrl_ff.vld && !mac_busy)
      else $error("accumulator read before the pipeline drained");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == flc_pkg::ST_OUT)
      else $error("result word raised outside the output state");

   a_taps_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != flc_pkg::ST_IDLE |->
         taps_ff != '0 && taps_ff <= CW'(MAX_TAPS) && CW'(out_cnt_ff) < taps_ff)
      else $error("tap or output count out of range");

   a_hist_cleared: assert property (@(posedge clock) disable iff (reset)
      out_go && final_out |=> hist_ff[0] == '0 && hist_ff[HIST_D-1] == '0)
      else $error("history not cleared after the final word");

endmodule

// ----- verif/full_linear_convolution_tb.sv -----
module full_linear_convolution_tb;

   localparam int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF;
   localparam int QUIET       = MAX_TAPS + 16;
   localparam int CYCLE_LIMIT = 3000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   flc_pkg::req_type               req_word = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   flc_pkg::rsp_type               rsp_word;
   logic                           csr_write = 1'b0;
   logic [flc_pkg::COUNT_BITS-1:0] csr_wdata = '0;

   // Local copy of the kernel, delay line and tap count.
   logic signed [flc_pkg::DATA_BITS-1:0] kernel_model [0:MAX_TAPS-1];
   logic signed [flc_pkg::DATA_BITS-1:0] history_model [0:MAX_TAPS-2];
   logic [flc_pkg::COUNT_BITS-1:0]       taps_model;

   flc_pkg::rsp_type pending_outputs [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      stall_left = 0;
   bit      bursts_on = 1'b1;

   full_linear_convolution i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The receiver stalls in random bursts while bursts are enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      flc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output word, expected none, actual %h", $time, rsp_word);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_word.conv_value !== want.conv_value) begin
               $display("%0t: conv_value expected %0d, actual %0d", $time,
                        want.conv_value, rsp_word.conv_value);
               mismatch_count++;
            end
            if (rsp_word.last_result !== want.last_result) begin
               $display("%0t: last_result expected %b, actual %b", $time,
                        want.last_result, rsp_word.last_result);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int active_taps();
      if (taps_model == 0)
         return 1;
      if (taps_model > MAX_TAPS)
         return MAX_TAPS;
      return taps_model;
   endfunction

   // One output from x and the delay line, after which x enters the delay line.
   function automatic logic signed [flc_pkg::OUT_BITS-1:0] mac_and_shift(
      logic signed [flc_pkg::DATA_BITS-1:0] x, int taps);
      logic signed [flc_pkg::OUT_BITS-1:0] acc;
      acc = kernel_model[0] * x;
      for (int i = 1; i < taps; i++)
         acc = acc + kernel_model[i] * history_model[i-1];
      for (int i = MAX_TAPS - 2; i > 0; i--)
         history_model[i] = history_model[i-1];
      history_model[0] = x;
      return acc;
   endfunction

   task automatic convolve_word(flc_pkg::req_type w);
      int               taps;
      flc_pkg::rsp_type r;
      if (w.op == flc_pkg::OP_LOAD) begin
         kernel_model[w.tap_index] = w.data_value;
      end else begin
         taps = active_taps();
         r.conv_value  = mac_and_shift(w.data_value, taps);
         r.last_result = w.last_sample && taps == 1;
         pending_outputs.push_back(r);
         if (w.last_sample) begin
            for (int t = 1; t < taps; t++) begin
               r.conv_value  = mac_and_shift('0, taps);
               r.last_result = (t == taps - 1);
               pending_outputs.push_back(r);
            end
            foreach (history_model[i])
               history_model[i] = '0;
         end
      end
   endtask

   // Valid is left high after acceptance; it is lowered only when a gap follows.
   task automatic send_word(flc_pkg::req_type w);
      if (bursts_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      convolve_word(w);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (QUIET) @(posedge clock);
   endtask

   task automatic write_tap_count(logic [flc_pkg::COUNT_BITS-1:0] value);
      wait_until_drained();
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      taps_model = value;
      csr_write <= 1'b0;
   endtask

   function automatic flc_pkg::req_type make_word(logic op,
                                                  logic [flc_pkg::INDEX_BITS-1:0] index,
                                                  logic signed [flc_pkg::DATA_BITS-1:0] value,
                                                  logic last);
      flc_pkg::req_type w;
      w.op          = op;
      w.tap_index   = index;
      w.data_value  = value;
      w.last_sample = last;
      return w;
   endfunction

   function automatic logic signed [flc_pkg::DATA_BITS-1:0] random_data();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         default: return flc_pkg::DATA_BITS'($urandom);
      endcase
   endfunction

   // Straight after reset: a zero kernel and a single tap.
   task automatic test_default_kernel();
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'sh7FFF, 1'b1));
      send_word(make_word(flc_pkg::OP_LOAD, 6'd63, 16'sh7FFF, 1'b1));
   endtask

   // A single tap: the last sample carries the final flag and has no tail.
   task automatic test_single_tap();
      send_word(make_word(flc_pkg::OP_LOAD, 6'd0, 16'sh8000, 1'b1));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd5, 16'sh8000, 1'b0));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd63, 16'sh7FFF, 1'b1));
   endtask

   // Tap count above the maximum falls back to the full kernel.
   task automatic test_full_kernel();
      write_tap_count(7'd127);
      send_word(make_word(flc_pkg::OP_LOAD, 6'd63, 16'sh8000, 1'b0));
      send_word(make_word(flc_pkg::OP_LOAD, 6'd21, 16'sh5555, 1'b0));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'h3F, 16'sh7FFF, 1'b0));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'h2A, 16'sh8000, 1'b1));
   endtask

   task automatic test_tap_count_edges();
      write_tap_count(7'd0);
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'sh1234, 1'b1));
      write_tap_count(7'd64);
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'sh8000, 1'b1));
   endtask

   // A stream without a last mark keeps its history across a tap count change.
   task automatic test_open_stream();
      write_tap_count(7'd3);
      send_word(make_word(flc_pkg::OP_LOAD, 6'd1, 16'sh7FFF, 1'b0));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'sh4000, 1'b0));
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'shC000, 1'b0));
      write_tap_count(7'd2);
      send_word(make_word(flc_pkg::OP_SAMPLE, 6'd0, 16'sh0001, 1'b1));
   endtask

   // Phases of a few coefficient loads followed by a signal, mostly ended by a last mark.
   task automatic test_random_streams(int target);
      int                             sent;
      int                             n_loads;
      int                             n_samples;
      logic [flc_pkg::COUNT_BITS-1:0] taps;
      flc_pkg::req_type               w;
      sent = 0;
      while (sent < target) begin
         if (sent >= target - 20)
            bursts_on = 1'b0;
         case ($urandom_range(0, 11))
            0:       taps = 7'd64;
            1:       taps = flc_pkg::COUNT_BITS'($urandom_range(65, 127));
            2:       taps = 7'd0;
            3:       taps = 7'd1;
            default: taps = flc_pkg::COUNT_BITS'($urandom_range(2, 10));
         endcase
         if ($urandom_range(0, 3) != 0)
            write_tap_count(taps);
         n_loads = $urandom_range(0, 4);
         for (int k = 0; k < n_loads; k++) begin
            w = make_word(flc_pkg::OP_LOAD, flc_pkg::INDEX_BITS'($urandom_range(0, 9)),
                          random_data(), 1'($urandom));
            if ($urandom_range(0, 3) == 0)
               w.tap_index = flc_pkg::INDEX_BITS'($urandom);
            send_word(w);
            sent++;
         end
         n_samples = $urandom_range(1, 6);
         for (int k = 0; k < n_samples; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_word(make_word(flc_pkg::OP_LOAD, flc_pkg::INDEX_BITS'($urandom),
                                   random_data(), 1'($urandom)));
               sent++;
            end
            w = make_word(flc_pkg::OP_SAMPLE, flc_pkg::INDEX_BITS'($urandom), random_data(),
                          k == n_samples - 1 && $urandom_range(0, 4) != 0);
            send_word(w);
            sent++;
         end
      end
   endtask

   initial begin
      foreach (kernel_model[i])
         kernel_model[i] = '0;
      foreach (history_model[i])
         history_model[i] = '0;
      taps_model = flc_pkg::TAP_COUNT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_kernel();
      test_single_tap();
      test_full_kernel();
      test_tap_count_edges();
      test_open_stream();
      test_random_streams(95);

      wait_until_drained();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/flc_pkg.sv
rtl/flc_ram.sv
rtl/flc_mac.sv
rtl/full_linear_convolution.sv
verif/full_linear_convolution_tb.sv
